>>> hw/rtl/b2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_pkg: shared types and tables for the Roman numeral encoder
// Command and status bundles between controller and datapath, digit shape
// and letter tables.
// ----------------------------------------------------------------------------
package b2r_pkg;

  localparam int unsigned VALUE_W  = 12;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned DEC_W    = 2;   // decade index: 3 thousands .. 0 units
  localparam int unsigned SLOT_W   = 2;   // letter slot within one digit
  localparam int unsigned LEN_W    = 3;   // letters per digit, 0 to 4
  localparam int unsigned MULT_W   = 14;  // holds 9 * 1000

  localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

  // Letter roles within a decade
  localparam logic [1:0] LET_ONE  = 2'd0;
  localparam logic [1:0] LET_FIVE = 2'd1;
  localparam logic [1:0] LET_TEN  = 2'd2;

  localparam logic [DEC_W-1:0] DEC_THOUSANDS = 2'd3;
  localparam logic [DEC_W-1:0] DEC_UNITS     = 2'd0;

  typedef struct packed {
    logic              load;      // capture in_value
    logic              split;     // extract digit of decade dec
    logic              emit;      // write letter (dec, slot) to output register
    logic              emit_err;  // write error result to output register
    logic [DEC_W-1:0]  dec;
    logic [SLOT_W-1:0] slot;
  } b2r_cmd_t;

  typedef struct packed {
    logic             in_ok;     // in_value lies in 1 to 3999
    logic             out_free;  // output register can take a result now
    logic [LEN_W-1:0] len;       // letter count of the current digit
    logic             last;      // current letter ends the run
  } b2r_status_t;

  // Number of letters a decimal digit takes
  function automatic logic [LEN_W-1:0] shape_len(input logic [DIGIT_W-1:0] d);
    logic [LEN_W-1:0] n;
    case (d)
      4'd1, 4'd5:             n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
      4'd3, 4'd7:             n = 3'd3;
      4'd8:                   n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

  // Letter role of slot s for digit d
  function automatic logic [1:0] shape_code(input logic [DIGIT_W-1:0] d,
                                            input logic [SLOT_W-1:0]  s);
    logic [1:0] c;
    case (d)
      4'd4:             c = (s == 2'd0) ? LET_ONE : LET_FIVE;
      4'd5:             c = LET_FIVE;
      4'd6, 4'd7, 4'd8: c = (s == 2'd0) ? LET_FIVE : LET_ONE;
      4'd9:             c = (s == 2'd0) ? LET_ONE : LET_TEN;
      default:          c = LET_ONE;
    endcase
    return c;
  endfunction

  // ASCII letter for a decade and letter role
  function automatic logic [CHAR_W-1:0] decade_letter(input logic [DEC_W-1:0] dec,
                                                      input logic [1:0]       c);
    logic [CHAR_W-1:0] ch;
    case ({dec, c})
      {2'd0, LET_ONE}:  ch = "I";
      {2'd0, LET_FIVE}: ch = "V";
      {2'd0, LET_TEN}:  ch = "X";
      {2'd1, LET_ONE}:  ch = "X";
      {2'd1, LET_FIVE}: ch = "L";
      {2'd1, LET_TEN}:  ch = "C";
      {2'd2, LET_ONE}:  ch = "C";
      {2'd2, LET_FIVE}: ch = "D";
      {2'd2, LET_TEN}:  ch = "M";
      default:          ch = "M";  // thousands use only the one-letter
    endcase
    return ch;
  endfunction

  // k times the weight of decade dec
  function automatic logic [MULT_W-1:0] decade_mult(input logic [DEC_W-1:0] dec,
                                                    input logic [DIGIT_W-1:0] k);
    logic [MULT_W-1:0] w;
    case (dec)
      2'd3:    w = 14'd1000;
      2'd2:    w = 14'd100;
      2'd1:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return MULT_W'(w * MULT_W'(k));
  endfunction

endpackage

>>> hw/rtl/binary_to_roman_numeral_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_roman_numeral_encoder_core: binary to Roman numeral encoder
// Converts a 12-bit integer into its subtractive Roman numeral, one ASCII
// letter per result, most significant letter first.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                        Direction
//  -------   -------------------------------------------  ---------
//  in        in_valid, in_stall, in_value[11:0]           request in
//  out       out_valid, out_stall, out_character[7:0],    result out
//            out_last, out_error
//
// One request at a time. The accept step plus four digit-split steps (one
// per decade, a parallel compare against the decade's multiples) come first;
// then one letter per cycle while the output is not stalled, up to 15, with
// each empty thousands, hundreds or tens digit before the final letter passed
// over in its own step (15 letters for 3888).
// Out-of-range values (0, above 3999) give one error result.
// A stalled output holds the letter walk; in_stall stays high until the
// last letter of the run is in the output register.
// Reset (rst_n, synchronous) clears the state machine and output valid only.
//
module binary_to_roman_numeral_encoder_core
  import b2r_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [VALUE_W-1:0]  in_value,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAR_W-1:0]   out_character,
  output logic                out_last,
  output logic                out_error
);

  b2r_cmd_t    cmd;
  b2r_status_t status;

  // Controller: accept, split sequencing, decade and slot walk
  b2r_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: remainder, digits, letter lookup, output register
  b2r_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last),
    .out_error     (out_error)
  );

endmodule

>>> hw/rtl/b2r_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_ctrl: sequencing state machine
// Takes a request, steps the digit split, then walks decades and letter
// slots until the final letter is written out.
// ----------------------------------------------------------------------------
module b2r_ctrl
  import b2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  b2r_status_t status,
  output b2r_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SPLIT = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_ERR   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [DEC_W-1:0]  dec_r, dec_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    dec_nxt      = dec_r;
    slot_nxt     = slot_r;
    cmd          = '0;
    cmd.dec      = dec_r;
    cmd.slot     = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          dec_nxt   = DEC_THOUSANDS;
          slot_nxt  = '0;
          state_nxt = status.in_ok ? ST_SPLIT : ST_ERR;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        if (dec_r == DEC_UNITS) begin
          dec_nxt   = DEC_THOUSANDS;
          state_nxt = ST_EMIT;
        end else begin
          dec_nxt = dec_r - 2'd1;
        end
      end
      ST_EMIT: begin
        if (status.len == '0) begin
          // empty digit: skip to the next decade
          dec_nxt = dec_r - 2'd1;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last) begin
            state_nxt = ST_IDLE;
          end else if ({1'b0, slot_r} == status.len - 3'd1) begin
            slot_nxt = '0;
            dec_nxt  = dec_r - 2'd1;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end
      end
      ST_ERR: begin
        if (status.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dec_r   <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      dec_r   <= dec_nxt;
      slot_r  <= slot_nxt;
    end
  end

endmodule

>>> hw/rtl/b2r_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_dpath: digit split and letter datapath
// Holds the remainder and four decimal digits, looks up letters and keeps
// the output register.
// ----------------------------------------------------------------------------
module b2r_dpath
  import b2r_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [VALUE_W-1:0]  in_value,
  input  b2r_cmd_t            cmd,
  output b2r_status_t         status,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAR_W-1:0]   out_character,
  output logic                out_last,
  output logic                out_error
);

  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic [DIGIT_W-1:0] digit_r [4];
  logic [DIGIT_W-1:0] split_digit;
  logic [DIGIT_W-1:0] cur_digit;
  logic               lower_zero;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  char_r;
  logic               last_r;
  logic               error_r;

  // Digit of the current decade: highest k with k*weight <= remainder
  always_comb begin
    split_digit = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, rem_r} >= decade_mult(cmd.dec, DIGIT_W'(k))) begin
        split_digit = DIGIT_W'(k);
      end
    end
    rem_nxt = VALUE_W'({2'b00, rem_r} - decade_mult(cmd.dec, split_digit));
  end

  assign cur_digit = digit_r[cmd.dec];

  // High if every decade below the current one is empty
  always_comb begin
    lower_zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (DEC_W'(i) < cmd.dec && digit_r[i] != '0) begin
        lower_zero = 1'b0;
      end
    end
  end

  assign status.in_ok    = (in_value != '0) && (in_value <= MAX_VALUE);
  assign status.out_free = !out_valid_r || !out_stall;
  assign status.len      = shape_len(cur_digit);
  assign status.last     = lower_zero && ({1'b0, cmd.slot} == status.len - 3'd1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= in_value;
    end else if (cmd.split) begin
      rem_r            <= rem_nxt;
      digit_r[cmd.dec] <= split_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_err) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      char_r  <= decade_letter(cmd.dec, shape_code(cur_digit, cmd.slot));
      last_r  <= status.last;
      error_r <= 1'b0;
    end else if (cmd.emit_err) begin
      char_r  <= '0;
      last_r  <= 1'b1;
      error_r <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;
  assign out_error     = error_r;

endmodule
